[sv/line_track_filter_macros.svh]
// Assertion macros for the line tracker checker.
`ifndef LINE_TRACK_FILTER_MACROS_SVH
`define LINE_TRACK_FILTER_MACROS_SVH
`define LTF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LTF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[sv/ltf_pkg.sv]
package ltf_pkg;
  localparam int TrackDepth = 16;
  localparam int OutLines   = 8;
  localparam int FrameLines = 8;
  localparam logic [7:0] IdMax = 8'd255;

  localparam logic [1:0] CFG_MAX_JUMP = 2'd0;
  localparam logic [1:0] CFG_APPEAR   = 2'd1;
  localparam logic [1:0] CFG_VANISH   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] position;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] track_position;
    logic [7:0]         track_id;
    logic               present;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] pos;
    logic [7:0]         id;
    logic signed [7:0]  cnt;
  } track_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M_SCAN, ST_M_APPLY, ST_INS_SHIFT, ST_A_SCAN, ST_A_APPLY,
    ST_REM_SHIFT, ST_EMIT, ST_EMIT_WAIT, ST_EMPTY
  } state_t;

  // saturating 8-bit signed clamp
  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    if (v > 10'sd127) return 8'sd127;
    if (v < -10'sd128) return -8'sd128;
    return v[7:0];
  endfunction
endpackage

[sv/ltf_dist.sv]
// Shared distance unit: |a-b| and compare against the running best.
module ltf_dist (
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic               have_best,
  input  logic [16:0]        best,
  output logic [16:0]        span,
  output logic               better
);
  logic signed [16:0] diff;
  assign diff   = 17'(a) - 17'(b);
  assign span   = diff[16] ? 17'(-diff) : 17'(diff);
  assign better = !have_best || (span <= best);
endmodule

[sv/line_track_filter.sv]
// line_track_filter: frame-to-frame line tracker, one shared distance unit.
// Detection beats are taken back to back while idle. An end-of-frame beat starts
// matching of each buffered detection (with a shifted insert on a miss), then ageing
// of each track (with a shifted removal when it expires), then a table scan for output
// and the closing beat, plus any output stall. Not ready meanwhile.
// Reset (synchronous, rst_n low) empties table and buffer by count; registers
// return to max_jump 30, appear_count 3, vanish_count 3.
module line_track_filter #(
  parameter int TRACK_DEPTH = ltf_pkg::TrackDepth,
  parameter int OUT_LINES   = ltf_pkg::OutLines,
  parameter int FRAME_LINES = ltf_pkg::FrameLines
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ltf_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ltf_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import ltf_pkg::*;

  localparam int TW = $clog2(TRACK_DEPTH + 1);
  localparam int TI = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int FW = $clog2(FRAME_LINES + 1);
  localparam int FI = (FRAME_LINES > 1) ? $clog2(FRAME_LINES) : 1;
  localparam int OW = $clog2(OUT_LINES + 1);

  // Small register tables; each index is a counter chosen by the sequencer.
  track_t              tab_r [TRACK_DEPTH];
  logic signed [15:0]  buf_r [FRAME_LINES];
  logic [TW-1:0]       tcnt_r;
  logic [FW-1:0]       fcnt_r;
  logic [7:0]          next_id_r;
  logic [15:0]         max_jump_r;
  logic [6:0]          appear_r, vanish_r;

  state_t state_r, state_nxt;
  logic [FW-1:0] i_r;       // detection index
  logic [TW-1:0] j_r;       // track index
  logic [TW-1:0] k_r;       // shift pointer
  logic [16:0]   best_r;
  logic          have_r;
  logic [TI-1:0] bi_r;
  logic [OW-1:0] n_r;
  out_item_t     out_r;
  logic          ov_r;

  // Distance unit operands are selected by phase.
  logic signed [15:0] da, db;
  logic [16:0] span;
  logic better;
  logic scan_t;
  assign scan_t = (state_r == ST_M_SCAN);
  assign da = scan_t ? buf_r[i_r[FI-1:0]] : tab_r[j_r[TI-1:0]].pos;
  assign db = scan_t ? tab_r[j_r[TI-1:0]].pos : buf_r[i_r[FI-1:0]];

  ltf_dist u_dist (
    .a(da), .b(db), .have_best(have_r), .best(best_r), .span(span), .better(better)
  );

  logic signed [7:0] a8, v8;
  assign a8 = 8'(signed'({1'b0, appear_r}));
  assign v8 = 8'(signed'({1'b0, vanish_r}));
  logic miss;
  assign miss = !have_r || (best_r > {1'b0, max_jump_r});

  // Confirmed test of the entry under j.
  logic signed [7:0] jc;
  logic conf;
  assign jc   = tab_r[j_r[TI-1:0]].cnt;
  assign conf = (jc == a8) || (jc < 0 && jc > -v8);

  // Aged counter for the entry under j.
  logic signed [7:0] aged;
  always_comb begin
    if (jc > 0 && jc < a8) aged = sat8(-10'(signed'(v8)));
    else if (jc == a8)     aged = -8'sd1;
    else                   aged = sat8(10'(signed'(jc)) - 10'sd1);
  end

  logic [7:0] id_new;
  assign id_new = (next_id_r >= IdMax) ? 8'd1 : next_id_r + 8'd1;

  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:
        if (in_valid && in_data.kind) state_nxt = ST_M_SCAN;
      ST_M_SCAN:
        if (i_r == fcnt_r) state_nxt = ST_A_SCAN;
        else if (j_r == tcnt_r) state_nxt = ST_M_APPLY;
      ST_M_APPLY:
        state_nxt = (miss && tcnt_r < TW'(TRACK_DEPTH)) ? ST_INS_SHIFT : ST_M_SCAN;
      ST_INS_SHIFT:
        if (k_r == '0 || tab_r[TI'(k_r - 1'b1)].pos <= buf_r[i_r[FI-1:0]])
          state_nxt = ST_M_SCAN;
      ST_A_SCAN:
        if (j_r == tcnt_r) state_nxt = ST_EMIT;
        else if (i_r == fcnt_r) state_nxt = ST_A_APPLY;
      ST_A_APPLY:
        if (miss && aged <= -v8) state_nxt = ST_REM_SHIFT;
        else state_nxt = ST_A_SCAN;
      ST_REM_SHIFT:
        if (k_r + 1'b1 >= tcnt_r) state_nxt = ST_A_SCAN;
      ST_EMIT:
        if (j_r == tcnt_r || n_r == OW'(OUT_LINES))
          state_nxt = (n_r == '0) ? ST_EMPTY : ST_EMIT_WAIT;
        else if (conf && !(ov_r && !out_ready) && !(ov_r && out_r.last))
          state_nxt = ST_EMIT;
      ST_EMIT_WAIT:
        if (!ov_r || out_ready) state_nxt = ST_IDLE;
      ST_EMPTY:
        if (!ov_r || out_ready) state_nxt = ST_EMIT_WAIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result beat staged until the next is known, so the final one can carry last.
  logic pend_r;
  out_item_t pend_item_r;

  // Handshake outputs and the load strobe of the output register.
  logic emit_end, out_free, out_load;
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    emit_end  = (j_r == tcnt_r) || (n_r == OW'(OUT_LINES));
    out_free  = !ov_r || out_ready;
    case (state_r)
      ST_EMIT:      out_load = pend_r && out_free && (emit_end || conf);
      ST_EMIT_WAIT: out_load = pend_r && out_free;
      ST_EMPTY:     out_load = out_free;
      default:      out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tcnt_r <= '0; fcnt_r <= '0; next_id_r <= '0;
      max_jump_r <= 16'd30; appear_r <= 7'd3; vanish_r <= 7'd3;
      ov_r <= 1'b0; pend_r <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0; n_r <= '0; have_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= out_load || (ov_r && !out_ready);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_JUMP: max_jump_r <= cfg_data;
          CFG_APPEAR:   appear_r   <= cfg_data[6:0];
          CFG_VANISH:   vanish_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          i_r <= '0; j_r <= '0; have_r <= 1'b0;
          if (in_valid && !in_data.kind && fcnt_r < FW'(FRAME_LINES)) begin
            buf_r[fcnt_r[FI-1:0]] <= in_data.position;
            fcnt_r <= fcnt_r + 1'b1;
          end
        end
        ST_M_SCAN: begin
          if (i_r == fcnt_r) begin
            j_r <= '0; i_r <= '0; have_r <= 1'b0;
          end else if (j_r != tcnt_r) begin
            if (better) begin
              best_r <= span; have_r <= 1'b1; bi_r <= j_r[TI-1:0];
            end
            j_r <= j_r + 1'b1;
          end
        end
        ST_M_APPLY: begin
          if (miss) begin
            k_r <= tcnt_r;
            if (tcnt_r >= TW'(TRACK_DEPTH)) begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            tab_r[bi_r].pos <= buf_r[i_r[FI-1:0]];
            if (tab_r[bi_r].cnt < 0 || tab_r[bi_r].cnt == a8) tab_r[bi_r].cnt <= a8;
            else tab_r[bi_r].cnt <= sat8(10'(signed'(tab_r[bi_r].cnt)) + 10'sd1);
            i_r <= i_r + 1'b1;
          end
          j_r <= '0; have_r <= 1'b0;
        end
        ST_INS_SHIFT: begin
          if (k_r == '0 || tab_r[TI'(k_r - 1'b1)].pos <= buf_r[i_r[FI-1:0]]) begin
            tab_r[k_r[TI-1:0]] <= '{pos: buf_r[i_r[FI-1:0]], id: id_new, cnt: 8'sd1};
            next_id_r <= id_new;
            tcnt_r <= tcnt_r + 1'b1;
            i_r <= i_r + 1'b1;
          end else begin
            tab_r[k_r[TI-1:0]] <= tab_r[TI'(k_r - 1'b1)];
            k_r <= k_r - 1'b1;
          end
        end
        ST_A_SCAN: begin
          if (j_r == tcnt_r) begin
            j_r <= '0; n_r <= '0; fcnt_r <= '0;
          end else if (i_r != fcnt_r) begin
            if (better) begin
              best_r <= span; have_r <= 1'b1;
            end
            i_r <= i_r + 1'b1;
          end
        end
        ST_A_APPLY: begin
          i_r <= '0; have_r <= 1'b0;
          if (miss) begin
            tab_r[j_r[TI-1:0]].cnt <= aged;
            if (aged <= -v8) k_r <= j_r;
            else j_r <= j_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_REM_SHIFT: begin
          if (k_r + 1'b1 >= tcnt_r) begin
            tcnt_r <= tcnt_r - 1'b1;
          end else begin
            tab_r[k_r[TI-1:0]] <= tab_r[TI'(k_r + 1'b1)];
            k_r <= k_r + 1'b1;
          end
        end
        ST_EMIT: begin
          // one result in hand is staged in pend until the next is known
          if (j_r == tcnt_r || n_r == OW'(OUT_LINES)) begin
            if (pend_r && (!ov_r || out_ready)) begin
              out_r <= '{track_position: pend_item_r.track_position,
                         track_id: pend_item_r.track_id, present: 1'b1, last: 1'b1};
              pend_r <= 1'b0;
            end
          end else if (!conf) begin
            j_r <= j_r + 1'b1;
          end else if (!pend_r) begin
            pend_item_r <= '{track_position: tab_r[j_r[TI-1:0]].pos,
                             track_id: tab_r[j_r[TI-1:0]].id, present: 1'b1, last: 1'b0};
            pend_r <= 1'b1; n_r <= n_r + 1'b1; j_r <= j_r + 1'b1;
          end else if (!ov_r || out_ready) begin
            out_r <= pend_item_r;
            pend_item_r <= '{track_position: tab_r[j_r[TI-1:0]].pos,
                             track_id: tab_r[j_r[TI-1:0]].id, present: 1'b1, last: 1'b0};
            n_r <= n_r + 1'b1; j_r <= j_r + 1'b1;
          end
        end
        ST_EMIT_WAIT: begin
          if (pend_r && (!ov_r || out_ready)) begin
            out_r <= '{track_position: pend_item_r.track_position,
                       track_id: pend_item_r.track_id, present: 1'b1, last: 1'b1};
            pend_r <= 1'b0;
          end
        end
        ST_EMPTY: begin
          if (!ov_r || out_ready) begin
            out_r <= '{track_position: '0, track_id: '0, present: 1'b0, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[sv/ltf_checker.sv]
module ltf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ltf_pkg::out_item_t out_data
);
  `include "line_track_filter_macros.svh"
  `LTF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `LTF_ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && !out_data.present, out_data.last)
  `LTF_ASSERT_IMP(a_in_held, clk, rst_n, out_valid && !out_data.last, !(in_valid && in_ready))
  `LTF_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_data.present, out_data.track_id == 8'd0)
endmodule

bind line_track_filter ltf_checker u_ltf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[tb/line_track_checker.sv]
module line_track_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ltf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ltf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 frames_seen,
  output int                 tracks_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ltf_pkg::*;

  localparam int MaxTracks = TrackDepth;

  int trk_pos [MaxTracks];
  int trk_id  [MaxTracks];
  int trk_cnt [MaxTracks];
  int n_tracks;
  int id_seq;
  int det_buf [FrameLines];
  int n_det;
  int jump_lim, appear_lim, vanish_lim;
  out_item_t track_report_q[$];

  function automatic int clamp8(int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  function automatic int gap(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic add_track(int p);
    int k;
    if (n_tracks >= MaxTracks) return;
    k = n_tracks;
    while (k > 0 && trk_pos[k-1] > p) begin
      trk_pos[k] = trk_pos[k-1];
      trk_id[k]  = trk_id[k-1];
      trk_cnt[k] = trk_cnt[k-1];
      k--;
    end
    id_seq = (id_seq >= 255) ? 1 : id_seq + 1;
    trk_pos[k] = p;
    trk_id[k]  = id_seq;
    trk_cnt[k] = 1;
    n_tracks++;
  endtask

  task automatic drop_track(int idx);
    for (int k = idx; k < n_tracks - 1; k++) begin
      trk_pos[k] = trk_pos[k+1];
      trk_id[k]  = trk_id[k+1];
      trk_cnt[k] = trk_cnt[k+1];
    end
    n_tracks--;
  endtask

  task automatic close_frame();
    int best, bi, d, n, i;
    out_item_t r;
    for (int f = 0; f < n_det; f++) begin
      d = det_buf[f];
      best = -1;
      bi = 0;
      for (int j = 0; j < n_tracks; j++)
        if (best < 0 || gap(d, trk_pos[j]) <= best) begin
          best = gap(d, trk_pos[j]);
          bi = j;
        end
      if (best < 0 || best > jump_lim) add_track(d);
      else begin
        trk_pos[bi] = d;
        trk_cnt[bi] = (trk_cnt[bi] < 0 || trk_cnt[bi] == appear_lim) ? appear_lim
                      : clamp8(trk_cnt[bi] + 1);
      end
    end
    i = 0;
    while (i < n_tracks) begin
      best = -1;
      for (int j = 0; j < n_det; j++)
        if (best < 0 || gap(trk_pos[i], det_buf[j]) <= best)
          best = gap(trk_pos[i], det_buf[j]);
      if (best < 0 || best > jump_lim) begin
        if (trk_cnt[i] > 0 && trk_cnt[i] < appear_lim) trk_cnt[i] = clamp8(-vanish_lim);
        else if (trk_cnt[i] == appear_lim) trk_cnt[i] = -1;
        else trk_cnt[i] = clamp8(trk_cnt[i] - 1);
        if (trk_cnt[i] <= -vanish_lim) begin
          drop_track(i);
          continue;
        end
      end
      i++;
    end
    n = 0;
    for (int k = 0; k < n_tracks && n < OutLines; k++)
      if (trk_cnt[k] == appear_lim || (trk_cnt[k] < 0 && trk_cnt[k] > -vanish_lim)) begin
        r.track_position = 16'(trk_pos[k]);
        r.track_id = 8'(trk_id[k]);
        r.present = 1'b1;
        r.last = 1'b0;
        track_report_q.push_back(r);
        n++;
      end
    if (n == 0) begin
      r = '0;
      r.last = 1'b1;
      track_report_q.push_back(r);
    end else begin
      track_report_q[track_report_q.size()-1].last = 1'b1;
    end
    n_det = 0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      n_tracks = 0; id_seq = 0; n_det = 0;
      jump_lim = 30; appear_lim = 3; vanish_lim = 3;
      track_report_q.delete();
    end else begin
      // result beat first: it belongs to an earlier frame
      if (out_valid && out_ready) begin
        tracks_seen <= tracks_seen + out_data.present;
        if (track_report_q.size() == 0) begin
          $error("unexpected result beat %p", out_data);
          errs++;
        end else begin
          want = track_report_q.pop_front();
          if (want.track_position !== out_data.track_position) begin
            $error("track_position: expected %0d, got %0d", want.track_position,
                   out_data.track_position);
            errs++;
          end
          if (want.track_id !== out_data.track_id) begin
            $error("track_id: expected %0d, got %0d", want.track_id, out_data.track_id);
            errs++;
          end
          if (want.present !== out_data.present) begin
            $error("present: expected %0b, got %0b", want.present, out_data.present);
            errs++;
          end
          if (want.last !== out_data.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_JUMP: jump_lim = cfg_data;
          CFG_APPEAR:   appear_lim = cfg_data[6:0];
          CFG_VANISH:   vanish_lim = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == 1'b0) begin
          if (n_det < FrameLines) begin
            det_buf[n_det] = int'(in_data.position);
            n_det++;
          end
        end else begin
          close_frame();
          frames_seen <= frames_seen + 1;
        end
      end
    end
    fail_count <= fail_count + errs;
    pending <= track_report_q.size();
  end
endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ltf_pkg::*;

  localparam int StallLimit = 20000; // idle cycles before the watchdog bites

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count, pending, frames_seen, tracks_seen;
  int send_idle_pct = 0;   // chance in a hundred the sender holds a beat back
  int recv_idle_pct = 0;   // chance in a hundred the receiver stalls
  bit hold_off = 1'b0;     // long receiver hold-off to back the block up
  int quiet_cycles = 0;

  // clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_track_filter uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  line_track_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .frames_seen, .tracks_seen
  );

  // receiver: random stalls, or held low through a hold-off
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: counts cycles where no beat moves on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("watchdog: no beat for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // one beat on the input channel, with an optional random gap before it;
  // valid stays up into the next beat unless a gap drops it
  task automatic send_beat(bit kind, logic [15:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.kind <= kind;
    in_data.position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for every expected beat, then let the block settle before a write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0 || in_valid) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // one frame of detections around a set of lines, with jitter and noise
  task automatic send_frame(int base, int lines, int jitter);
    int n;
    n = $urandom_range(lines);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_beat(1'b0, 16'($urandom));              // stray detection
      else
        send_beat(1'b0, 16'(base + k * 200 + $signed($urandom_range(2 * jitter)) - jitter));
    end
    send_beat(1'b1, 16'($urandom));                   // end of frame, payload ignored
  endtask

  int base;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty frame, extremes, full buffer, buffer overflow
    send_beat(1'b1, 16'h0000);
    send_beat(1'b0, 16'h8000);
    send_beat(1'b0, 16'h7fff);
    send_beat(1'b0, 16'hffff);
    send_beat(1'b1, 16'hffff);
    for (int k = 0; k < 10; k++) send_beat(1'b0, 16'(k * 50));   // two dropped
    send_beat(1'b1, 16'h0000);
    for (int k = 0; k < 3; k++) begin
      send_beat(1'b0, 16'h8000);
      send_beat(1'b0, 16'h7fff);
      send_beat(1'b1, 16'h5555);
    end
    drain();

    // settings: extremes, then ordinary ones, then the reset defaults
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_MAX_JUMP, 16'hffff); write_reg(CFG_APPEAR, 16'd1);
                 write_reg(CFG_VANISH, 16'd1); end
        1: begin write_reg(CFG_MAX_JUMP, 16'd0); write_reg(CFG_APPEAR, 16'd127);
                 write_reg(CFG_VANISH, 16'd127); end
        2: begin write_reg(CFG_MAX_JUMP, 16'd40); write_reg(CFG_APPEAR, 16'd2);
                 write_reg(CFG_VANISH, 16'd2); end
        3: begin write_reg(CFG_MAX_JUMP, 16'd25); write_reg(CFG_APPEAR, 16'd1);
                 write_reg(CFG_VANISH, 16'd4); end
        4: begin write_reg(CFG_MAX_JUMP, 16'd60); write_reg(CFG_APPEAR, 16'd3);
                 write_reg(CFG_VANISH, 16'd0); end
        default: begin write_reg(CFG_MAX_JUMP, 16'd30); write_reg(CFG_APPEAR, 16'd3);
                 write_reg(CFG_VANISH, 16'd3); end
      endcase
      cfg_valid <= 1'b0;
      // idling profile per phase: sender 12 / receiver 83, swapped, then none
      if (phase < 2) begin send_idle_pct = 12; recv_idle_pct = 83; end
      else if (phase < 4) begin send_idle_pct = 83; recv_idle_pct = 12; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      base = $signed($urandom_range(20000)) - 10000;
      for (int f = 0; f < 4; f++) begin
        send_frame(base, 8, 20);
      end
      if (phase == 4) begin
        // receiver holds off while frames keep coming: the block backs up
        fork
          begin hold_off = 1'b1; repeat (400) @(posedge clk); hold_off = 1'b0; end
          for (int f = 0; f < 4; f++) send_frame(base, 6, 10);
        join
      end
      drain();
    end

    $display("covered %0d frames and %0d track beats over six register settings",
             frames_seen, tracks_seen);
    $display("idling profiles: sender-heavy, receiver-heavy, none, plus a long hold-off");
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
